/* design/pdlp_pkg.sv */
// ----------------------------------------------------------------------------
// pdlp_pkg
// Shared types and constants of the prefixed decimal list parser.
// ----------------------------------------------------------------------------
package pdlp_pkg;

	localparam int MAX_FIELDS_DEF = 16;
	localparam int CMD_DEPTH      = 2;

	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NO_EQUALS    = 3'd1,
		ST_WRONG_PREFIX = 3'd2,
		ST_BAD_NUMBER   = 3'd3,
		ST_TOO_FEW      = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       frame_end;
		logic [7:0] expected_prefix;
		logic [4:0] expected_count;
	} item_t;

	typedef struct packed {
		logic [15:0] value;
		logic [3:0]  field_index;
		status_t     status;
		logic        surplus;
		logic        last;
	} result_t;

	typedef struct packed {
		status_t    status;
		logic       surplus;
		logic [4:0] count;
	} cmd_t;

endpackage

/* design/pdlp_front.sv */
// ----------------------------------------------------------------------------
// pdlp_front
// Byte parser: checks the prefix, accumulates fields into the value buffer
// and queues one frame transaction with its final status at frame end.
// ----------------------------------------------------------------------------
module pdlp_front #(
	parameter int MAX_FIELDS = pdlp_pkg::MAX_FIELDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  pdlp_pkg::item_t                   item,
	input  logic                              cmd_full,
	output logic                              cmd_push,
	output pdlp_pkg::cmd_t                    cmd,
	input  logic                              rel_valid,
	output logic                              buf_we,
	output logic [$clog2(MAX_FIELDS > 1 ? MAX_FIELDS : 2)-1:0] buf_waddr,
	output logic [15:0]                       buf_wdata
);

	localparam int IDX_W = $clog2(MAX_FIELDS > 1 ? MAX_FIELDS : 2);

	typedef enum logic [2:0] {
		PH_PREFIX = 3'b001,
		PH_FIELDS = 3'b010,
		PH_IGNORE = 3'b100
	} phase_t;

	logic [15:0]       acc_q, acc_d;
	logic              ovf_q, ovf_d;
	logic              digit_q, digit_d;
	logic              badch_q, badch_d;
	logic [4:0]        fcount_q, fcount_d;
	phase_t            phase_q, phase_d;
	logic [1:0]        plen_q, plen_d;
	logic              pmatch_q, pmatch_d;
	pdlp_pkg::status_t err_q, err_d;
	logic              extra_q, extra_d;
	logic              busy_q;

	logic              fire;
	logic              frame_done;
	logic [4:0]        n;
	logic [19:0]       prod;
	logic              we;
	logic [4:0]        waddr_cnt;
	logic [15:0]       wdata;
	pdlp_pkg::status_t fin_status;

	assign item_ready = !cmd_full && !busy_q;
	assign fire       = item_valid && item_ready;
	assign frame_done = fire && item.frame_end;

	always_comb begin
		if (item.expected_count == 5'd0) begin
			n = 5'd1;
		end else if (32'(item.expected_count) > 32'(MAX_FIELDS)) begin
			n = 5'(MAX_FIELDS);
		end else begin
			n = item.expected_count;
		end
	end

	always_comb begin
		acc_d      = acc_q;
		ovf_d      = ovf_q;
		digit_d    = digit_q;
		badch_d    = badch_q;
		fcount_d   = fcount_q;
		phase_d    = phase_q;
		plen_d     = plen_q;
		pmatch_d   = pmatch_q;
		err_d      = err_q;
		extra_d    = extra_q;
		we         = 1'b0;
		waddr_cnt  = fcount_q;
		wdata      = acc_q;
		fin_status = pdlp_pkg::ST_OK;
		prod       = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {16'd0, item.char_byte[3:0]};

		unique case (phase_q)
			PH_PREFIX: begin
				if (item.char_byte == pdlp_pkg::CH_EQUALS) begin
					if (plen_q == 2'd1 && pmatch_q) begin
						phase_d = PH_FIELDS;
						acc_d   = '0;
						ovf_d   = 1'b0;
						digit_d = 1'b0;
						badch_d = 1'b0;
					end else begin
						err_d   = pdlp_pkg::ST_WRONG_PREFIX;
						phase_d = PH_IGNORE;
					end
				end else begin
					if (plen_q == 2'd0) begin
						pmatch_d = (item.char_byte == item.expected_prefix);
					end
					if (plen_q < 2'd2) begin
						plen_d = plen_q + 2'd1;
					end
				end
			end
			PH_FIELDS: begin
				if (item.char_byte == pdlp_pkg::CH_COLON) begin
					if (!digit_q || ovf_q || badch_q) begin
						err_d   = pdlp_pkg::ST_BAD_NUMBER;
						phase_d = PH_IGNORE;
					end else begin
						we       = 1'b1;
						fcount_d = fcount_q + 5'd1;
						acc_d    = '0;
						ovf_d    = 1'b0;
						digit_d  = 1'b0;
						badch_d  = 1'b0;
						if ({1'b0, fcount_q} + 6'd1 >= {1'b0, n}) begin
							extra_d = 1'b1;
							phase_d = PH_IGNORE;
						end
					end
				end else if (item.char_byte >= pdlp_pkg::CH_ZERO &&
						item.char_byte <= pdlp_pkg::CH_NINE) begin
					if (prod[19:16] != 4'd0) begin
						ovf_d = 1'b1;
					end
					acc_d   = prod[15:0];
					digit_d = 1'b1;
				end else begin
					badch_d = 1'b1;
				end
			end
			PH_IGNORE: begin
			end
			default: begin
			end
		endcase

		if (item.frame_end) begin
			fin_status = err_d;
			if (phase_d == PH_PREFIX) begin
				fin_status = pdlp_pkg::ST_NO_EQUALS;
			end else if (phase_d == PH_FIELDS) begin
				if (!digit_d || ovf_d || badch_d) begin
					fin_status = pdlp_pkg::ST_BAD_NUMBER;
				end else begin
					we        = 1'b1;
					waddr_cnt = fcount_d;
					wdata     = acc_d;
					if ({1'b0, fcount_d} + 6'd1 < {1'b0, n}) begin
						fin_status = pdlp_pkg::ST_TOO_FEW;
					end
				end
			end
		end
	end

	assign buf_we    = fire && we && (32'(waddr_cnt) < 32'(MAX_FIELDS));
	assign buf_waddr = IDX_W'(waddr_cnt);
	assign buf_wdata = wdata;

	assign cmd_push    = frame_done;
	assign cmd.status  = fin_status;
	assign cmd.surplus = extra_d;
	assign cmd.count   = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			digit_q  <= 1'b0;
			badch_q  <= 1'b0;
			fcount_q <= '0;
			phase_q  <= PH_PREFIX;
			plen_q   <= '0;
			pmatch_q <= 1'b1;
			err_q    <= pdlp_pkg::ST_OK;
			extra_q  <= 1'b0;
		end else if (frame_done) begin
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			digit_q  <= 1'b0;
			badch_q  <= 1'b0;
			fcount_q <= '0;
			phase_q  <= PH_PREFIX;
			plen_q   <= '0;
			pmatch_q <= 1'b1;
			err_q    <= pdlp_pkg::ST_OK;
			extra_q  <= 1'b0;
		end else if (fire) begin
			acc_q    <= acc_d;
			ovf_q    <= ovf_d;
			digit_q  <= digit_d;
			badch_q  <= badch_d;
			fcount_q <= fcount_d;
			phase_q  <= phase_d;
			plen_q   <= plen_d;
			pmatch_q <= pmatch_d;
			err_q    <= err_d;
			extra_q  <= extra_d;
		end
	end

	// Hold input while an ok frame reads the shared value buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (frame_done && fin_status == pdlp_pkg::ST_OK) begin
			busy_q <= 1'b1;
		end else if (rel_valid) begin
			busy_q <= 1'b0;
		end
	end

endmodule

/* design/pdlp_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// pdlp_cmd_fifo
// Short queue of frame transactions between the parser and the emitter.
// ----------------------------------------------------------------------------
module pdlp_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pdlp_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output pdlp_pkg::cmd_t rdata
);

	localparam int PW = $clog2(pdlp_pkg::CMD_DEPTH);

	pdlp_pkg::cmd_t entries_q [pdlp_pkg::CMD_DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [PW:0]    cnt_q;

	assign full     = (cnt_q == (PW + 1)'(pdlp_pkg::CMD_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = entries_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(pdlp_pkg::CMD_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(pdlp_pkg::CMD_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* design/pdlp_back.sv */
// ----------------------------------------------------------------------------
// pdlp_back
// Result emitter: holds the value buffer and plays out each queued frame
// transaction as one error result or the list of parsed values.
// ----------------------------------------------------------------------------
module pdlp_back #(
	parameter int MAX_FIELDS = pdlp_pkg::MAX_FIELDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              buf_we,
	input  logic [$clog2(MAX_FIELDS > 1 ? MAX_FIELDS : 2)-1:0] buf_waddr,
	input  logic [15:0]                       buf_wdata,
	input  logic                              cmd_valid,
	input  pdlp_pkg::cmd_t                    cmd,
	output logic                              cmd_pop,
	output logic                              rel_valid,
	output logic                              result_valid,
	input  logic                              result_ready,
	output pdlp_pkg::result_t                 result
);

	localparam int IDX_W = $clog2(MAX_FIELDS > 1 ? MAX_FIELDS : 2);

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_READ = 3'b010,
		BK_LOAD = 3'b100
	} bk_state_t;

	logic [15:0]       mem_q [2**IDX_W];
	logic [15:0]       rdata_q;
	bk_state_t         st_q;
	pdlp_pkg::cmd_t    cur_q;
	logic [4:0]        idx_q;
	logic              res_valid_q;
	pdlp_pkg::result_t res_q;

	logic              free;
	logic              load_err;
	logic              take_ok;
	logic              load_ok;
	logic              is_last;

	always_ff @(posedge clk) begin
		if (buf_we) begin
			mem_q[buf_waddr] <= buf_wdata;
		end
		rdata_q <= mem_q[IDX_W'(idx_q)];
	end

	assign free     = !res_valid_q || result_ready;
	assign is_last  = ({1'b0, idx_q} + 6'd1 == {1'b0, cur_q.count});
	assign load_err = (st_q == BK_IDLE) && cmd_valid && cmd.status != pdlp_pkg::ST_OK && free;
	assign take_ok  = (st_q == BK_IDLE) && cmd_valid && cmd.status == pdlp_pkg::ST_OK;
	assign load_ok  = (st_q == BK_LOAD) && free;

	assign cmd_pop   = load_err || take_ok;
	assign rel_valid = load_ok && is_last;

	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_err || load_ok) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (st_q)
				BK_IDLE: begin
					if (take_ok) begin
						idx_q <= '0;
						st_q  <= BK_READ;
					end
				end
				BK_READ: begin
					st_q <= BK_LOAD;
				end
				BK_LOAD: begin
					if (load_ok) begin
						if (is_last) begin
							st_q <= BK_IDLE;
						end else begin
							idx_q <= idx_q + 5'd1;
							st_q  <= BK_READ;
						end
					end
				end
				default: begin
					st_q <= BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_ok) begin
			cur_q <= cmd;
		end
		if (load_err) begin
			res_q.value       <= '0;
			res_q.field_index <= '0;
			res_q.status      <= cmd.status;
			res_q.surplus     <= 1'b0;
			res_q.last        <= 1'b1;
		end else if (load_ok) begin
			res_q.value       <= rdata_q;
			res_q.field_index <= idx_q[3:0];
			res_q.status      <= pdlp_pkg::ST_OK;
			res_q.surplus     <= cur_q.surplus;
			res_q.last        <= is_last;
		end
	end

endmodule

/* design/prefixed_decimal_list_parser_top.sv */
// ----------------------------------------------------------------------------
// prefixed_decimal_list_parser_top
// Parses reply frames of the form P=123:456:789 into a list of 16-bit values.
// ----------------------------------------------------------------------------
// The parser takes one frame byte per cycle unless the command queue is full
// or an ok frame still holds the value buffer. At the frame end byte it
// queues a frame transaction; the emitter then returns a single error result
// from its result register, or the values of an ok frame one at a time, each
// through its read and load states, paced by the registered read of the value
// buffer. The value buffer keeps its contents across frames, so after the
// frame end byte of an ok frame with n values the input stalls until the last
// value has been loaded, which the result side delays when it holds back. Error
// frames do not stall the input unless the two-entry command queue is full.
module prefixed_decimal_list_parser_top #(
	parameter int MAX_FIELDS = pdlp_pkg::MAX_FIELDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  pdlp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output pdlp_pkg::result_t result
);

	localparam int IDX_W = $clog2(MAX_FIELDS > 1 ? MAX_FIELDS : 2);

	logic             cmd_push;
	logic             cmd_pop;
	logic             cmd_full;
	logic             cmd_nonempty;
	pdlp_pkg::cmd_t   cmd_in;
	pdlp_pkg::cmd_t   cmd_out;
	logic             rel_valid;
	logic             buf_we;
	logic [IDX_W-1:0] buf_waddr;
	logic [15:0]      buf_wdata;

	pdlp_front #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cmd_full   (cmd_full),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in),
		.rel_valid  (rel_valid),
		.buf_we     (buf_we),
		.buf_waddr  (buf_waddr),
		.buf_wdata  (buf_wdata)
	);

	pdlp_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.wdata    (cmd_in),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.nonempty (cmd_nonempty),
		.rdata    (cmd_out)
	);

	pdlp_back #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.buf_we       (buf_we),
		.buf_waddr    (buf_waddr),
		.buf_wdata    (buf_wdata),
		.cmd_valid    (cmd_nonempty),
		.cmd          (cmd_out),
		.cmd_pop      (cmd_pop),
		.rel_valid    (rel_valid),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("frame transaction pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_nonempty)
		else $error("frame transaction popped from an empty queue");

	a_error_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != pdlp_pkg::ST_OK) |->
		(result.last && result.value == 16'd0 && !result.surplus))
		else $error("error result not a single zero-valued last item");

	a_release_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		rel_valid |=> (result_valid && result.last && result.status == pdlp_pkg::ST_OK))
		else $error("value buffer released without a final ok result");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the prefixed decimal list parser. Frames are built
// byte by byte: a short directed set for the prefix, number and count corner
// cases, then random frames that are mostly well formed, with injected errors,
// surplus tails, count changes and raw noise. A scoreboard predicts each
// frame's results as its bytes are accepted and checks every result in order.
// Both sides idle at random, and the result side holds off once for a long
// stretch so that the parser backs up.
// ----------------------------------------------------------------------------
module testbench;
	import pdlp_pkg::*;

	localparam int MAX_FIELDS = MAX_FIELDS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TARGET_BYTES = 230;
	localparam int HOLD_CYCLES = 500;
	localparam int HOLD_AFTER = 12;

	typedef enum logic [1:0] {
		PH_PREFIX,
		PH_FIELDS,
		PH_IGNORE
	} phase_t;

	class frame_scoreboard;
		logic [15:0] value_store [MAX_FIELDS];
		logic [31:0] accum;
		bit          overflowed;
		bit          digit_seen;
		bit          bad_char;
		int          field_count;
		phase_t      phase;
		int          prefix_len;
		bit          prefix_ok;
		status_t     frame_status;
		bit          extra_data;
		result_t     expected_results [$];
		int          mismatches;
		int          checked;
		int          status_tally [5];
		int          surplus_frames;

		function new();
			clear_frame();
		endfunction

		function void clear_field();
			accum = '0;
			overflowed = 1'b0;
			digit_seen = 1'b0;
			bad_char = 1'b0;
		endfunction

		function void clear_frame();
			clear_field();
			field_count = 0;
			phase = PH_PREFIX;
			prefix_len = 0;
			prefix_ok = 1'b1;
			frame_status = ST_OK;
			extra_data = 1'b0;
		endfunction

		function bit close_field();
			if (!digit_seen || overflowed || bad_char) begin
				frame_status = ST_BAD_NUMBER;
				phase = PH_IGNORE;
				return 1'b0;
			end
			if (field_count < MAX_FIELDS)
				value_store[field_count] = accum[15:0];
			field_count++;
			clear_field();
			return 1'b1;
		endfunction

		function void note_item(item_t it);
			int      n;
			result_t r;
			n = it.expected_count;
			if (n == 0)
				n = 1;
			if (n > MAX_FIELDS)
				n = MAX_FIELDS;
			case (phase)
				PH_PREFIX: begin
					if (it.char_byte == CH_EQUALS) begin
						if (prefix_len == 1 && prefix_ok) begin
							phase = PH_FIELDS;
							clear_field();
						end else begin
							frame_status = ST_WRONG_PREFIX;
							phase = PH_IGNORE;
						end
					end else begin
						if (prefix_len == 0)
							prefix_ok = (it.char_byte == it.expected_prefix);
						if (prefix_len < 2)
							prefix_len++;
					end
				end
				PH_FIELDS: begin
					if (it.char_byte == CH_COLON) begin
						if (close_field() && field_count >= n) begin
							extra_data = 1'b1;
							phase = PH_IGNORE;
						end
					end else if (it.char_byte >= CH_ZERO && it.char_byte <= CH_NINE) begin
						accum = accum * 10 + (it.char_byte - CH_ZERO);
						if (accum > 32'hFFFF) begin
							overflowed = 1'b1;
							accum = accum & 32'hFFFF;
						end
						digit_seen = 1'b1;
					end else begin
						bad_char = 1'b1;
					end
				end
				default: ;
			endcase
			if (!it.frame_end)
				return;
			if (phase == PH_PREFIX) begin
				frame_status = ST_NO_EQUALS;
			end else if (phase == PH_FIELDS) begin
				if (close_field() && field_count < n)
					frame_status = ST_TOO_FEW;
			end
			status_tally[int'(frame_status)]++;
			if (frame_status != ST_OK) begin
				r = '0;
				r.status = frame_status;
				r.last = 1'b1;
				expected_results.push_back(r);
			end else begin
				if (extra_data)
					surplus_frames++;
				for (int i = 0; i < n; i++) begin
					r = '0;
					r.value = value_store[i];
					r.field_index = 4'(i);
					r.status = ST_OK;
					r.surplus = extra_data;
					r.last = (i == n - 1);
					expected_results.push_back(r);
				end
			end
			clear_frame();
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_result(result_t got);
			result_t want;
			checked++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", got));
				return;
			end
			want = expected_results.pop_front();
			if (got.value !== want.value)
				report_mismatch($sformatf("value %0d, want %0d", got.value, want.value));
			if (got.field_index !== want.field_index)
				report_mismatch($sformatf("field_index %0d, want %0d",
					got.field_index, want.field_index));
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.surplus !== want.surplus)
				report_mismatch($sformatf("surplus %b, want %b", got.surplus, want.surplus));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %b, want %b", got.last, want.last));
		endtask
	endclass

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	frame_scoreboard board;
	item_t           frame_q [$];
	logic [7:0]      cur_prefix;
	logic [4:0]      cur_count;
	int              bytes_sent;
	int              frames_sent;
	int              cycles = 0;

	prefixed_decimal_list_parser_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic void add_char(logic [7:0] c);
		item_t it;
		it.char_byte = c;
		it.frame_end = 1'b0;
		it.expected_prefix = cur_prefix;
		it.expected_count = cur_count;
		frame_q.push_back(it);
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endfunction

	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_COLON);
		return c;
	endfunction

	// Empty, overflowing and non-digit fields are injected at a low rate.
	function automatic void add_field();
		int unsigned v;
		int          sel;
		sel = $urandom_range(0, 39);
		if (sel == 0)
			return;
		if (sel == 1) begin
			v = $urandom_range(65536, 999999);
		end else begin
			case ($urandom_range(0, 5))
				0: v = 0;
				1: v = 65535;
				2: v = $urandom_range(0, 9);
				3: v = $urandom_range(10, 99);
				4: v = $urandom_range(100, 999);
				default: v = $urandom_range(0, 65535);
			endcase
		end
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) add_char(CH_ZERO);
		add_text($sformatf("%0d", v));
		if (sel == 2)
			add_char(junk_char());
	endfunction

	function automatic void build_random_frame();
		int         n;
		int         nf;
		int         shape;
		int         shrink_at;
		logic [7:0] c;
		do
			cur_prefix = 8'($urandom_range(0, 255));
		while (cur_prefix == CH_EQUALS);
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
		cur_count = 5'(n);
		case ($urandom_range(0, 9))
			0: if (n == 1) cur_count = 5'd0;
			1: begin
				n = MAX_FIELDS;
				cur_count = 5'($urandom_range(17, 31));
			end
			default: ;
		endcase
		if ($urandom_range(0, 99) < 12) begin
			repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
			return;
		end
		case ($urandom_range(0, 19))
			0: ;
			1: begin
				add_char(cur_prefix);
				add_char(8'($urandom_range(0, 255)));
			end
			2: begin
				do
					c = 8'($urandom_range(0, 255));
				while (c == cur_prefix || c == CH_EQUALS);
				add_char(c);
			end
			default: add_char(cur_prefix);
		endcase
		if ($urandom_range(0, 19) != 0)
			add_char(CH_EQUALS);
		shape = $urandom_range(0, 9);
		nf = (shape < 2 || cur_count > MAX_FIELDS) ? $urandom_range(0, n > 3 ? 3 : n - 1) : n;
		shrink_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, nf) : -1;
		for (int i = 0; i < nf; i++) begin
			if (i == shrink_at)
				cur_count = 5'($urandom_range(1, n));
			if (i > 0)
				add_char(CH_COLON);
			add_field();
		end
		if (shrink_at == nf)
			cur_count = 5'($urandom_range(1, n));
		if (nf == n && (shape == 2 || shape == 3)) begin
			add_char(CH_COLON);
			repeat ($urandom_range(0, 4)) add_char(8'($urandom_range(0, 255)));
		end
		if (frame_q.size() == 0)
			add_char(cur_prefix);
	endfunction

	task automatic send_item(item_t it, int gap);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		board.note_item(it);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		bit burst;
		burst = ($urandom_range(0, 3) == 0);
		frame_q[frame_q.size() - 1].frame_end = 1'b1;
		foreach (frame_q[i])
			send_item(frame_q[i], burst ? 0 : $urandom_range(0, 15));
		frame_q.delete();
		frames_sent++;
	endtask

	task automatic directed_frame(logic [7:0] pfx, logic [4:0] cnt, string s);
		cur_prefix = pfx;
		cur_count = cnt;
		add_text(s);
		send_frame();
	endtask

	initial begin
		int      taken;
		int      gap;
		bit      held;
		result_ready = 1'b0;
		taken = 0;
		held = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held && taken == HOLD_AFTER) begin
				held = 1'b1;
				gap = HOLD_CYCLES;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			end
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
			board.check_result(result);
			taken++;
			@(negedge clk);
		end
	end

	initial begin
		int waited;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cur_prefix = "A";
		cur_count = 5'd1;
		bytes_sent = 0;
		frames_sent = 0;
		board = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_frame("A", 5'd1, "=");
		directed_frame("A", 5'd1, "A");
		directed_frame("A", 5'd1, "AB=0");
		directed_frame("A", 5'd1, "B=0");
		directed_frame("A", 5'd0, "A=65535:x");
		directed_frame("A", 5'd1, "A=65536");
		directed_frame("A", 5'd2, "A=:");
		directed_frame("A", 5'd31, "A=1");

		while (bytes_sent < TARGET_BYTES) begin
			build_random_frame();
			send_frame();
		end
		item_valid <= 1'b0;

		waited = 0;
		while (board.expected_results.size() != 0 && waited < CYCLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);

		$display("Sent %0d bytes in %0d frames; checked %0d results, %0d frames with surplus.",
			bytes_sent, frames_sent, board.checked, board.surplus_frames);
		$display("Frame outcomes: ok %0d, no equals %0d, wrong prefix %0d, bad number %0d, too few %0d.",
			board.status_tally[0], board.status_tally[1], board.status_tally[2],
			board.status_tally[3], board.status_tally[4]);
		if (board.mismatches == 0 && board.expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/pdlp_pkg.sv
design/pdlp_front.sv
design/pdlp_cmd_fifo.sv
design/pdlp_back.sv
design/prefixed_decimal_list_parser_top.sv
tb/testbench.sv
